FILE: rtl/cht_pkg.sv
// Shared types, constants and codes for the chained hash table.
package cht_pkg;

  localparam int unsigned BucketsDefault    = 256;
  localparam int unsigned NodesDefault      = 1024;
  localparam int unsigned KeyWidthDefault   = 32;
  localparam int unsigned ValueWidthDefault = 32;

  localparam int unsigned FuncWidth   = 2;
  localparam int unsigned BucketWidth = 8;
  localparam int unsigned KeyInWidth  = 32;
  localparam int unsigned ValInWidth  = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 11;

  typedef enum logic [FuncWidth-1:0] {
    FuncLookup = 2'd0,
    FuncInsert = 2'd1,
    FuncRemove = 2'd2,
    FuncClear  = 2'd3
  } func_e;

  typedef enum logic [StatusWidth-1:0] {
    StatusOk       = 2'd0,
    StatusNotFound = 2'd1,
    StatusDup      = 2'd2,
    StatusFull     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StHeadRd,
    StHeadWait,
    StNodeRd,
    StNodeWait,
    StCheck,
    StInsert,
    StRemove,
    StClear,
    StDone
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic head_rd;
    logic head_load;
    logic node_rd;
    logic advance;
    logic insert;
    logic remove;
    logic sweep;
    logic sweep_reset;
    logic finish;
  } cht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_nil;
    logic key_match;
    logic step_limit;
    logic pool_empty;
    logic sweep_last;
    logic [FuncWidth-1:0] func;
  } cht_stat_t;

endpackage

FILE: rtl/chained_hash_table_core.sv
// Top level of the chained hash table: controller plus datapath.
// A request reads its bucket head, then walks the chain one node at a time until a key match,
// the chain end or the step limit; a successful insert or remove then writes in a further state.
// Clear sweeps the bucket heads and node links, resets the entry count and rebuilds the free list.
// One request at a time; busy stays high until done_o.
// After reset a sweep over the bucket heads and node links builds the free list; the receiver cannot stall.
module chained_hash_table_core #(
  parameter int unsigned BUCKETS     = cht_pkg::BucketsDefault,
  parameter int unsigned NODES       = cht_pkg::NodesDefault,
  parameter int unsigned KEY_WIDTH   = cht_pkg::KeyWidthDefault,
  parameter int unsigned VALUE_WIDTH = cht_pkg::ValueWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [cht_pkg::FuncWidth-1:0]   func_i,
  input  logic [cht_pkg::BucketWidth-1:0] bucket_i,
  input  logic [cht_pkg::KeyInWidth-1:0]  key_i,
  input  logic [cht_pkg::ValInWidth-1:0]  value_i,
  output logic                            done_o,
  output logic [cht_pkg::StatusWidth-1:0] status_o,
  output logic                            found_o,
  output logic [cht_pkg::ValInWidth-1:0]  value_out_o,
  output logic [cht_pkg::CountWidth-1:0]  entry_count_o
);
  import cht_pkg::*;

  cht_cmd_t  cmd;
  cht_stat_t stat;

  cht_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .done_o,
    .cmd_o(cmd), .stat_i(stat)
  );

  cht_datapath #(
    .BUCKETS(BUCKETS), .NODES(NODES), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .func_i, .bucket_i, .key_i, .value_i,
    .status_o, .found_o, .value_out_o, .entry_count_o
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe outside a request");
  a_full_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o && status_o == StatusFull |-> stat.pool_empty)
    else $error("full status with free nodes");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("block stays busy after a result");

endmodule

FILE: rtl/cht_datapath.sv
// Datapath of the chained hash table: memories, chain walker, result register.
module cht_datapath #(
  parameter int unsigned BUCKETS     = cht_pkg::BucketsDefault,
  parameter int unsigned NODES       = cht_pkg::NodesDefault,
  parameter int unsigned KEY_WIDTH   = cht_pkg::KeyWidthDefault,
  parameter int unsigned VALUE_WIDTH = cht_pkg::ValueWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cht_pkg::cht_cmd_t                   cmd_i,
  output cht_pkg::cht_stat_t                  stat_o,
  input  logic [cht_pkg::FuncWidth-1:0]       func_i,
  input  logic [cht_pkg::BucketWidth-1:0]     bucket_i,
  input  logic [cht_pkg::KeyInWidth-1:0]      key_i,
  input  logic [cht_pkg::ValInWidth-1:0]      value_i,
  output logic [cht_pkg::StatusWidth-1:0]     status_o,
  output logic                                found_o,
  output logic [cht_pkg::ValInWidth-1:0]      value_out_o,
  output logic [cht_pkg::CountWidth-1:0]      entry_count_o
);
  import cht_pkg::*;

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW = $clog2(NODES + 1);
  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned SW = (BUCKETS > NODES) ? BW + 1 : IW + 1;
  localparam int unsigned KW = (KEY_WIDTH < KeyInWidth) ? KEY_WIDTH : KeyInWidth;
  localparam int unsigned VW = (VALUE_WIDTH < ValInWidth) ? VALUE_WIDTH : ValInWidth;
  localparam int unsigned BucketCodes = 2 ** BucketWidth;
  localparam logic [NW-1:0] Nil = NW'(NODES);

  logic [NW-1:0] head_mem [BUCKETS];
  logic [KW-1:0] key_mem  [NODES];
  logic [VW-1:0] val_mem  [NODES];
  logic [NW-1:0] link_mem [NODES];

  logic [FuncWidth-1:0] func_q;
  logic [BW-1:0]        bkt_q;
  logic [KW-1:0]        key_q;
  logic [VW-1:0]        val_q;
  logic [NW-1:0]        cur_q, prev_q, free_q, head_rd_q;
  logic [NW-1:0]        count_q, steps_q;
  logic [KW-1:0]        nkey_q;
  logic [VW-1:0]        nval_q;
  logic [NW-1:0]        nlink_q;
  logic [SW-1:0]        sweep_q;
  logic [StatusWidth-1:0] status_q;
  logic                 found_q;
  logic [ValInWidth-1:0] vout_q;

  logic [IW-1:0] cur_idx, free_idx, prev_idx;
  assign cur_idx  = cur_q[IW-1:0];
  assign free_idx = free_q[IW-1:0];
  assign prev_idx = prev_q[IW-1:0];

  logic [BW-1:0] bkt_in;
  logic [BW-1:0] bkt_lut [BucketCodes];
  for (genvar g = 0; g < BucketCodes; g++) begin : g_bkt_lut
    localparam int unsigned BktMod = g % BUCKETS;
    assign bkt_lut[g] = BW'(BktMod);
  end
  assign bkt_in = bkt_lut[bucket_i];

  logic hit;
  assign hit = (cur_q != Nil) && (nkey_q == key_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.head_rd) head_rd_q <= head_mem[bkt_q];
    if (cmd_i.node_rd) begin
      nkey_q  <= key_mem[cur_idx];
      nval_q  <= val_mem[cur_idx];
      nlink_q <= link_mem[cur_idx];
    end
    if (cmd_i.sweep) begin
      if (sweep_q < SW'(BUCKETS)) head_mem[sweep_q[BW-1:0]] <= Nil;
      if (sweep_q < SW'(NODES)) link_mem[sweep_q[IW-1:0]] <= NW'(sweep_q) + NW'(1);
    end
    if (cmd_i.insert) begin
      key_mem[free_idx]  <= key_q;
      val_mem[free_idx]  <= val_q;
      link_mem[free_idx] <= head_rd_q;
      head_mem[bkt_q]    <= free_q;
    end
    if (cmd_i.remove) begin
      if (prev_q != Nil) link_mem[prev_idx] <= nlink_q;
      else               head_mem[bkt_q]    <= nlink_q;
      link_mem[cur_idx] <= free_q;
    end
  end

  // Free-list head of the pool needs the link of the free node on insert.
  logic [NW-1:0] free_link_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture || cmd_i.insert || cmd_i.remove) free_link_q <= link_mem[free_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      bkt_q  <= bkt_in;
      key_q  <= key_i[KW-1:0];
      val_q  <= value_i[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= Nil;
      prev_q <= Nil;
      steps_q <= '0;
      free_q <= '0;
      count_q <= '0;
      sweep_q <= '0;
      status_q <= StatusOk;
      found_q <= 1'b0;
      vout_q <= '0;
    end else begin
      if (cmd_i.sweep_reset) sweep_q <= '0;
      else if (cmd_i.sweep) sweep_q <= sweep_q + SW'(1);
      if (cmd_i.sweep) begin
        free_q <= '0;
        count_q <= '0;
      end
      if (cmd_i.head_load) begin
        cur_q <= head_rd_q;
        prev_q <= Nil;
        steps_q <= '0;
      end
      if (cmd_i.advance) begin
        prev_q <= cur_q;
        cur_q <= nlink_q;
        steps_q <= steps_q + NW'(1);
      end
      if (cmd_i.insert) begin
        free_q <= free_link_q;
        count_q <= count_q + NW'(1);
      end
      if (cmd_i.remove) begin
        free_q <= cur_q;
        if (count_q != '0) count_q <= count_q - NW'(1);
      end
      if (cmd_i.finish) begin
        status_q <= StatusOk;
        found_q <= 1'b0;
        vout_q <= '0;
        unique case (func_e'(func_q))
          FuncLookup: begin
            if (hit) begin
              found_q <= 1'b1;
              vout_q <= ValInWidth'(nval_q);
            end else status_q <= StatusNotFound;
          end
          FuncInsert: begin
            if (hit) begin
              status_q <= StatusDup;
              found_q <= 1'b1;
            end else if (free_q == Nil) status_q <= StatusFull;
          end
          FuncRemove: begin
            if (hit) found_q <= 1'b1;
            else status_q <= StatusNotFound;
          end
          FuncClear: ;
          default: ;
        endcase
      end
    end
  end

  assign stat_o.cur_nil    = (cur_q == Nil);
  assign stat_o.key_match  = hit;
  assign stat_o.step_limit = (steps_q >= NW'(NODES));
  assign stat_o.pool_empty = (free_q == Nil);
  assign stat_o.sweep_last = (sweep_q >= SW'((BUCKETS > NODES) ? BUCKETS - 1 : NODES - 1));
  assign stat_o.func       = func_q;

  assign status_o      = status_q;
  assign found_o       = found_q;
  assign value_out_o   = vout_q;
  assign entry_count_o = CountWidth'(count_q);

endmodule

FILE: rtl/cht_ctrl.sv
// Controller state machine of the chained hash table.
module cht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  output cht_pkg::cht_cmd_t  cmd_o,
  input  cht_pkg::cht_stat_t stat_i
);
  import cht_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StInit:     if (stat_i.sweep_last) state_d = StIdle;
      StIdle:     if (start_i) state_d = StHeadRd;
      StHeadRd: begin
        if (func_e'(stat_i.func) == FuncClear) state_d = StClear;
        else state_d = StHeadWait;
      end
      StHeadWait: state_d = StNodeRd;
      StNodeRd: begin
        if (stat_i.cur_nil || stat_i.step_limit) state_d = StCheck;
        else state_d = StNodeWait;
      end
      StNodeWait: state_d = StCheck;
      StCheck: begin
        if (!stat_i.cur_nil && !stat_i.key_match && !stat_i.step_limit) state_d = StNodeRd;
        else begin
          unique case (func_e'(stat_i.func))
            FuncInsert: state_d = (stat_i.key_match || stat_i.pool_empty) ? StDone : StInsert;
            FuncRemove: state_d = stat_i.key_match ? StRemove : StDone;
            default:    state_d = StDone;
          endcase
        end
      end
      StInsert:   state_d = StDone;
      StRemove:   state_d = StDone;
      StClear:    if (stat_i.sweep_last) state_d = StDone;
      StDone:     state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      StInit:     cmd_o.sweep = 1'b1;
      StIdle: begin
        busy_o = 1'b0;
        cmd_o.capture = start_i;
        cmd_o.sweep_reset = 1'b1;
      end
      StHeadRd:   cmd_o.head_rd = 1'b1;
      StHeadWait: cmd_o.head_load = 1'b1;
      StNodeRd:   cmd_o.node_rd = !stat_i.cur_nil;
      StNodeWait: ;
      StCheck: begin
        if (!stat_i.cur_nil && !stat_i.key_match && !stat_i.step_limit) cmd_o.advance = 1'b1;
        else cmd_o.finish = 1'b1;
      end
      StInsert:   cmd_o.insert = 1'b1;
      StRemove:   cmd_o.remove = 1'b1;
      StClear: begin
        cmd_o.sweep = 1'b1;
        cmd_o.finish = stat_i.sweep_last;
      end
      StDone:     done_o = 1'b1;
      default: ;
    endcase
  end

endmodule
